>>> rtl/core/brlc_pkg.sv
// ----------------------------------------------------------------------------
// brlc_pkg: shared types and constants of the byte run-length codec
// Status codes, mode codes, register map and the command passed from the
// front end to the back end through the command queue.
// ----------------------------------------------------------------------------
package brlc_pkg;

  localparam int unsigned LaneBytes = 4;
  localparam int unsigned CapW      = 24;
  localparam int unsigned ProdW     = 25;

  // longest run held before a pair is forced out
  localparam logic [7:0] MaxRun = 8'd255;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusFull    = 2'd1,
    StatusZeroRun = 2'd2,
    StatusOddLen  = 2'd3
  } status_e;

  typedef enum logic {
    ModeCompress = 1'b0,
    ModeExpand   = 1'b1
  } mode_e;

  typedef enum logic {
    RegMode     = 1'b0,
    RegCapacity = 1'b1
  } reg_idx_e;

  // rep = 0: data holds count bytes, already packed (count <= 4)
  // rep = 1: data[7:0] is repeated count times
  typedef struct packed {
    logic            rep;
    logic [31:0]     data;
    logic [7:0]      count;
    logic            eom;
    status_e         status;
    logic [CapW-1:0] total;
  } cmd_t;

  typedef struct packed {
    mode_e           mode;
    logic [CapW-1:0] capacity;
    logic            clear;
  } cfg_t;

endpackage

>>> rtl/core/brlc_intf.sv
// ----------------------------------------------------------------------------
// brlc_intf: request channels of the byte run-length codec
// Input channel carries one message byte, output channel one result word.
// ----------------------------------------------------------------------------
interface brlc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       in_last;

  modport source (output valid, output data_byte, output in_last, input ready);
  modport sink   (input valid, input data_byte, input in_last, output ready);
endinterface

interface brlc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_bytes;
  logic [2:0]  byte_count;
  logic        end_of_message;
  logic [1:0]  status;
  logic [23:0] total_length;

  modport source (output valid, output out_bytes, output byte_count,
                  output end_of_message, output status, output total_length,
                  input ready);
  modport sink   (input valid, input out_bytes, input byte_count,
                  input end_of_message, input status, input total_length,
                  output ready);
endinterface

>>> rtl/core/brlc_front.sv
// ----------------------------------------------------------------------------
// brlc_front: input front end
// Tracks runs / pending count bytes, checks capacity and turns each request
// into at most one command for the back end.
// ----------------------------------------------------------------------------
module brlc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  brlc_pkg::cfg_t     cfg_i,
  brlc_in_if.sink            in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output brlc_pkg::cmd_t     cmd_o
);

  localparam logic [brlc_pkg::ProdW-1:0] PairInc = brlc_pkg::ProdW'(2);

  logic [7:0]                 run_byte_q, run_byte_d;
  logic [7:0]                 run_len_q, run_len_d;
  logic                       run_open_q, run_open_d;
  logic [brlc_pkg::ProdW-1:0] prod_q, prod_d, prod_new, cap_ext;
  logic                       discard_q, discard_d;
  logic                       accept, ext, pair_out, eom;
  logic [7:0]                 din;
  brlc_pkg::status_e          status;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign din        = in_i.data_byte;
  assign cap_ext    = {1'b0, cfg_i.capacity};

  // run continues with this byte
  assign ext      = run_open_q && (din == run_byte_q) && (run_len_q < brlc_pkg::MaxRun);
  assign pair_out = run_open_q && !ext;

  always_comb begin
    run_byte_d = run_byte_q;
    run_len_d  = run_len_q;
    run_open_d = run_open_q;
    prod_d     = prod_q;
    discard_d  = discard_q;
    prod_new   = prod_q;
    status     = brlc_pkg::StatusOk;
    eom        = 1'b0;
    cmd_o      = '0;
    push_o     = 1'b0;

    if (accept) begin
      if (discard_q) begin
        if (in_i.in_last) begin
          discard_d = 1'b0;
        end
      end else begin
        if (cfg_i.mode == brlc_pkg::ModeCompress) begin
          if (pair_out) begin
            if (prod_q + PairInc > cap_ext) begin
              status = brlc_pkg::StatusFull;
            end else begin
              cmd_o.data[15:0] = {run_byte_q, run_len_q};
              cmd_o.count      = 8'd2;
              prod_new         = prod_q + PairInc;
            end
          end
          if (status == brlc_pkg::StatusOk) begin
            if (ext) begin
              run_len_d = run_len_q + 8'd1;
            end else begin
              run_byte_d = din;
              run_len_d  = 8'd1;
              run_open_d = 1'b1;
            end
            if (in_i.in_last) begin
              if (prod_new + PairInc > cap_ext) begin
                status = brlc_pkg::StatusFull;
              end else begin
                if (pair_out) begin
                  cmd_o.data[31:16] = {run_byte_d, run_len_d};
                end else begin
                  cmd_o.data[15:0] = {run_byte_d, run_len_d};
                end
                cmd_o.count = cmd_o.count + 8'd2;
                prod_new    = prod_new + PairInc;
              end
            end
          end
        end else begin
          if (!run_open_q) begin
            run_len_d  = din;
            run_open_d = 1'b1;
            if (in_i.in_last) begin
              status = brlc_pkg::StatusOddLen;
            end
          end else begin
            run_open_d = 1'b0;
            if (run_len_q == 8'd0) begin
              status = brlc_pkg::StatusZeroRun;
            end else if (prod_q + {17'd0, run_len_q} > cap_ext) begin
              status = brlc_pkg::StatusFull;
            end else begin
              cmd_o.rep       = 1'b1;
              cmd_o.data[7:0] = din;
              cmd_o.count     = run_len_q;
              prod_new        = prod_q + {17'd0, run_len_q};
            end
          end
        end

        eom          = in_i.in_last || (status != brlc_pkg::StatusOk);
        cmd_o.eom    = eom;
        cmd_o.status = status;
        cmd_o.total  = prod_new[brlc_pkg::CapW-1:0];
        push_o       = (cmd_o.count != 8'd0) || eom;
        if ((status != brlc_pkg::StatusOk) && !in_i.in_last) begin
          discard_d = 1'b1;
        end
        if (eom) begin
          run_byte_d = '0;
          run_len_d  = '0;
          run_open_d = 1'b0;
          prod_d     = '0;
        end else begin
          prod_d = prod_new;
        end
      end
    end

    // mode write drops the message in flight
    if (cfg_i.clear) begin
      run_byte_d = '0;
      run_len_d  = '0;
      run_open_d = 1'b0;
      prod_d     = '0;
      discard_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_byte_q <= '0;
      run_len_q  <= '0;
      run_open_q <= 1'b0;
      prod_q     <= '0;
      discard_q  <= 1'b0;
    end else begin
      run_byte_q <= run_byte_d;
      run_len_q  <= run_len_d;
      run_open_q <= run_open_d;
      prod_q     <= prod_d;
      discard_q  <= discard_d;
    end
  end

endmodule

>>> rtl/core/brlc_queue.sv
// ----------------------------------------------------------------------------
// brlc_queue: command queue between front and back end
// Small register FIFO, head visible combinationally.
// ----------------------------------------------------------------------------
module brlc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  brlc_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output brlc_pkg::cmd_t head_o,
  output logic           valid_o,
  output logic           full_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  brlc_pkg::cmd_t  mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == FullCnt);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

>>> rtl/core/brlc_back.sv
// ----------------------------------------------------------------------------
// brlc_back: output back end
// Splits the head command into result words of up to four bytes and holds
// each in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module brlc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  brlc_pkg::cmd_t head_i,
  input  logic           head_valid_i,
  output logic           pop_o,
  brlc_out_if.source     out_o
);

  localparam logic [7:0] LaneCnt = 8'(brlc_pkg::LaneBytes);

  logic              vld_q;
  logic              started_q, started_d;
  logic [7:0]        rem_q, rem_d, cur_rem;
  logic              load, last_word;
  logic [2:0]        nb;
  logic [31:0]       word;
  logic [31:0]       bytes_q;
  logic [2:0]        cnt_q;
  logic              eom_q;
  logic [1:0]        status_q;
  logic [23:0]       total_q;

  assign cur_rem   = started_q ? rem_q : head_i.count;
  assign last_word = (cur_rem <= LaneCnt);
  assign nb        = last_word ? cur_rem[2:0] : 3'(brlc_pkg::LaneBytes);
  assign load      = head_valid_i && (!vld_q || out_o.ready);
  assign pop_o     = load && last_word;

  always_comb begin
    word = head_i.data;
    if (head_i.rep) begin
      for (int k = 0; k < 4; k++) begin
        word[8*k +: 8] = (3'(k) < nb) ? head_i.data[7:0] : 8'd0;
      end
    end
  end

  always_comb begin
    started_d = started_q;
    rem_d     = rem_q;
    if (load) begin
      started_d = !last_word;
      rem_d     = cur_rem - LaneCnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      started_q <= 1'b0;
      rem_q     <= '0;
    end else begin
      if (load) begin
        vld_q <= 1'b1;
      end else if (out_o.ready) begin
        vld_q <= 1'b0;
      end
      started_q <= started_d;
      rem_q     <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bytes_q  <= word;
      cnt_q    <= nb;
      eom_q    <= head_i.eom && last_word;
      status_q <= (head_i.eom && last_word) ? head_i.status : brlc_pkg::StatusOk;
      total_q  <= (head_i.eom && last_word) ? head_i.total : '0;
    end
  end

  assign out_o.valid          = vld_q;
  assign out_o.out_bytes      = bytes_q;
  assign out_o.byte_count     = cnt_q;
  assign out_o.end_of_message = eom_q;
  assign out_o.status         = status_q;
  assign out_o.total_length   = total_q;

endmodule

>>> rtl/core/byte_run_length_codec_unit.sv
// ----------------------------------------------------------------------------
// byte_run_length_codec_unit: byte run-length codec, top level
// Compresses bytes into (count, value) pairs or expands pairs back into
// bytes, packed into 32-bit result words with an end-of-message word.
// ----------------------------------------------------------------------------
// Usage
//   in_i  : one message byte per request, in_last on the final byte.
//   out_o : result words, up to four bytes each, first byte in bits 7:0;
//           the last word of a message has end_of_message, status and the
//           message's total output length.
//   APB   : reg 0 (addr 0) mode, 0 compress / 1 expand; reg 1 (addr 4)
//           output capacity in bytes. Write only while idle; writing mode
//           drops any message in progress.
// Timing
//   With the queue empty and the output register free, an accepted request
//   goes into the command queue and its first word is then loaded into the
//   output register. Compress takes one byte a cycle while the queue has
//   room. Expand takes two requests per pair and splits it into ceil(count/4)
//   words, one per cycle out of the back end while the receiver takes them;
//   the input stalls once the command queue (QUEUE_DEPTH entries) is full.
// Reset
//   Mode compress, capacity all ones, queue and output register empty. No
//   clearing pass. A stalled receiver holds the output word; the front end
//   keeps taking requests until the queue fills.
// ----------------------------------------------------------------------------
module byte_run_length_codec_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  brlc_in_if.sink     in_i,
  brlc_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  brlc_pkg::mode_e                mode_q;
  logic [brlc_pkg::CapW-1:0]      cap_q;
  logic                           wr_en;
  brlc_pkg::reg_idx_e             reg_idx;
  brlc_pkg::cfg_t                 cfg;

  logic                           q_push, q_pop, q_valid, q_full;
  brlc_pkg::cmd_t                 q_in, q_head;

  // register file: write on access phase
  assign pready  = 1'b1;
  assign reg_idx = brlc_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= brlc_pkg::ModeCompress;
      cap_q  <= '1;
    end else if (wr_en) begin
      case (reg_idx)
        brlc_pkg::RegMode:     mode_q <= brlc_pkg::mode_e'(pwdata[0]);
        brlc_pkg::RegCapacity: cap_q  <= pwdata[brlc_pkg::CapW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      brlc_pkg::RegMode:     prdata = {31'd0, mode_q};
      brlc_pkg::RegCapacity: prdata = {8'd0, cap_q};
      default:               prdata = '0;
    endcase
  end

  assign cfg.mode     = mode_q;
  assign cfg.capacity = cap_q;
  assign cfg.clear    = wr_en && (reg_idx == brlc_pkg::RegMode);

  // front end: run tracking and checks
  brlc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (q_in)
  );

  // decouples front and back
  brlc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  // back end: word packing and output register
  brlc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .head_valid_i (q_valid),
    .pop_o        (q_pop),
    .out_o        (out_o)
  );

`ifndef SYNTH
  // only the final word carries status and length
  a_non_final_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.end_of_message |->
      out_o.status == brlc_pkg::StatusOk && out_o.total_length == '0)
    else $error("non-final word carries status or length");

  a_byte_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.byte_count <= 3'(brlc_pkg::LaneBytes))
    else $error("byte_count above lane count");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the byte run-length codec
// Drives message bytes through the request channel in random bursts and
// programs mode and capacity over APB. Every accepted byte is run through a
// local model of the codec, and each result word is compared with the oldest
// predicted word. A stalling receiver and a watchdog complete the bench.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ClkHalf     = 6;
  localparam int unsigned ResetCycles = 12;
  // no request of any kind for this long means the block has hung
  localparam int unsigned IdleLimit   = 2000;
  // margin after the last due word before the block is taken as idle
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseBytes  = 12;
  localparam logic [brlc_pkg::CapW-1:0] CapMax = '1;

  // one result word as the checker sees it
  typedef struct packed {
    logic [31:0]               bytes;
    logic [2:0]                count;
    logic                      eom;
    brlc_pkg::status_e         status;
    logic [brlc_pkg::CapW-1:0] total;
  } word_t;

  typedef logic [7:0] byte_q_t[$];

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  brlc_in_if  in_if ();
  brlc_out_if out_if ();

  byte_run_length_codec_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // --------------------------------------------------------------------------
  // Codec model state: programmed registers and the open message
  // --------------------------------------------------------------------------
  brlc_pkg::mode_e cur_mode;
  int unsigned cur_cap;
  logic [7:0]  run_val;
  int unsigned run_len;    // run length (compress) or pending count (expand)
  bit          run_open;
  int unsigned produced;   // output bytes of the current message so far
  bit          dropping;   // message ended early, skipping to its last byte
  logic [7:0]  step_bytes[$];
  word_t       words_due[$];

  int unsigned errors      = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned pat_age     = 0;
  logic [15:0] stall_pat   = '1;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  always begin
    clk_i = 1'b0;
    #ClkHalf;
    clk_i = 1'b1;
    #ClkHalf;
  end

  function automatic void clear_message();
    run_val  = '0;
    run_len  = 0;
    run_open = 1'b0;
    produced = 0;
  endfunction

  // queue the closed run as a (count, value) pair if capacity allows
  function automatic bit push_pair();
    if (produced + 2 > cur_cap) return 1'b0;
    step_bytes.push_back(run_len[7:0]);
    step_bytes.push_back(run_val);
    produced += 2;
    return 1'b1;
  endfunction

  // Work out the result words caused by one accepted byte and queue them.
  function automatic void predict_words(logic [7:0] b, bit last);
    brlc_pkg::status_e st;
    bit          fin;
    int unsigned nwords;
    int unsigned pos;
    word_t       w;
    st = brlc_pkg::StatusOk;
    step_bytes.delete();
    if (dropping) begin
      if (last) dropping = 1'b0;
      return;
    end
    if (cur_mode == brlc_pkg::ModeCompress) begin
      if (run_open && b == run_val && run_len < 32'(brlc_pkg::MaxRun)) begin
        run_len++;
      end else begin
        if (run_open && !push_pair()) st = brlc_pkg::StatusFull;
        if (st == brlc_pkg::StatusOk) begin
          run_val  = b;
          run_len  = 1;
          run_open = 1'b1;
        end
      end
      if (st == brlc_pkg::StatusOk && last && !push_pair()) st = brlc_pkg::StatusFull;
    end else begin
      if (!run_open) begin
        run_len  = 32'(b);
        run_open = 1'b1;
        if (last) st = brlc_pkg::StatusOddLen;
      end else begin
        run_open = 1'b0;
        // a zero count wins over the capacity check
        if (run_len == 0) begin
          st = brlc_pkg::StatusZeroRun;
        end else if (produced + run_len > cur_cap) begin
          st = brlc_pkg::StatusFull;
        end else begin
          repeat (run_len) step_bytes.push_back(b);
          produced += run_len;
        end
      end
    end
    fin = last || st != brlc_pkg::StatusOk;
    if (st != brlc_pkg::StatusOk && !last) dropping = 1'b1;
    // pack up to four bytes a word; a final step without data still ends
    nwords = (step_bytes.size() + brlc_pkg::LaneBytes - 1) / brlc_pkg::LaneBytes;
    if (nwords == 0 && fin) nwords = 1;
    pos = 0;
    for (int i = 0; i < nwords; i++) begin
      w = '0;
      for (int k = 0; k < brlc_pkg::LaneBytes && pos < step_bytes.size(); k++) begin
        w.bytes[8*k +: 8] = step_bytes[pos];
        w.count = w.count + 3'd1;
        pos++;
      end
      if (fin && i == nwords - 1) begin
        w.eom    = 1'b1;
        w.status = st;
        w.total  = produced[brlc_pkg::CapW-1:0];
      end
      words_due.push_back(w);
    end
    if (fin) clear_message();
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, bit last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      // now and then a long stretch without gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    @(negedge clk_i);
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.in_last   <= last;
    do @(posedge clk_i); while (!in_if.ready);
    predict_words(b, last);
  endtask

  task automatic send_message(byte_q_t msg);
    foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
  endtask

  // drop valid, let every due word arrive, then allow the pipeline to empty
  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // APB access, only with the block idle
  // --------------------------------------------------------------------------
  task automatic reg_write(brlc_pkg::reg_idx_e idx, logic [31:0] val);
    settle();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == brlc_pkg::RegMode) begin
      // a mode write also throws away any message in progress
      cur_mode = brlc_pkg::mode_e'(val[0]);
      clear_message();
      dropping = 1'b0;
    end else begin
      cur_cap = 32'(val[brlc_pkg::CapW-1:0]);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read_check(brlc_pkg::reg_idx_e idx, logic [31:0] want);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      errors++;
      $display("%0t: register %0d read, expected %h, got %h", $time, idx, want, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Random message builders
  // --------------------------------------------------------------------------
  // raw bytes with runs drawn from a two-value palette and a random fill
  function automatic byte_q_t make_raw_message();
    byte_q_t     msg;
    int unsigned len;
    int unsigned rl;
    logic [7:0]  v;
    logic [7:0]  pal0;
    logic [7:0]  pal1;
    len  = $urandom_range(1, 24);
    pal0 = 8'($urandom_range(0, 255));
    pal1 = 8'($urandom_range(0, 255));
    while (msg.size() < len) begin
      case ($urandom_range(0, 3))
        0:       v = pal0;
        1:       v = pal1;
        default: v = 8'($urandom_range(0, 255));
      endcase
      rl = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      repeat (rl) if (msg.size() < len) msg.push_back(v);
    end
    return msg;
  endfunction

  // mostly well-formed pairs with short counts; some noise and odd lengths
  function automatic byte_q_t make_pair_message();
    byte_q_t     msg;
    int unsigned npairs;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 9)) msg.push_back(8'($urandom_range(0, 255)));
      return msg;
    end
    npairs = $urandom_range(1, 5);
    repeat (npairs) begin
      msg.push_back(8'(($urandom_range(0, 19) == 0) ? $urandom_range(10, 255)
                                                    : $urandom_range(1, 9)));
      msg.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) void'(msg.pop_back());
    return msg;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_registers();
    reg_read_check(brlc_pkg::RegMode, 32'(brlc_pkg::ModeCompress));
    reg_read_check(brlc_pkg::RegCapacity, 32'(CapMax));
    reg_write(brlc_pkg::RegMode, 32'(brlc_pkg::ModeExpand));
    reg_read_check(brlc_pkg::RegMode, 32'(brlc_pkg::ModeExpand));
    reg_write(brlc_pkg::RegCapacity, 32'h00A5_C35A);
    reg_read_check(brlc_pkg::RegCapacity, 32'h00A5_C35A);
    reg_write(brlc_pkg::RegCapacity, 32'h0000_0000);
    reg_read_check(brlc_pkg::RegCapacity, 32'h0000_0000);
    reg_write(brlc_pkg::RegMode, 32'(brlc_pkg::ModeCompress));
    reg_write(brlc_pkg::RegCapacity, 32'(CapMax));
  endtask

  task automatic test_compress_cases();
    // single byte, and extreme values forming two runs
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    // capacity runs out part way: remainder up to the last byte is dropped
    reg_write(brlc_pkg::RegCapacity, 32'd3);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
    // no room at all: final word with no data
    reg_write(brlc_pkg::RegCapacity, 32'd0);
    send_byte(8'h80, 1'b1);
    // capacity lowered mid-message, seen at the next pair
    reg_write(brlc_pkg::RegCapacity, 32'(CapMax));
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    reg_write(brlc_pkg::RegCapacity, 32'd2);
    send_byte(8'h30, 1'b1);
    // mode write mid-message discards the open run
    reg_write(brlc_pkg::RegCapacity, 32'(CapMax));
    send_byte(8'h5A, 1'b0);
    send_byte(8'h5A, 1'b0);
    reg_write(brlc_pkg::RegMode, 32'(brlc_pkg::ModeCompress));
    send_byte(8'hA5, 1'b1);
  endtask

  task automatic test_expand_cases();
    reg_write(brlc_pkg::RegMode, 32'(brlc_pkg::ModeExpand));
    send_byte(8'd3, 1'b0);
    send_byte(8'h5A, 1'b1);
    // zero count
    send_byte(8'd0, 1'b0);
    send_byte(8'h07, 1'b1);
    // message ending on a count byte
    send_byte(8'd2, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'd5, 1'b1);
    // second run does not fit, rest of the message dropped
    reg_write(brlc_pkg::RegCapacity, 32'd4);
    send_byte(8'd4, 1'b0);
    send_byte(8'hEE, 1'b0);
    send_byte(8'd1, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h09, 1'b0);
    send_byte(8'h10, 1'b1);
    // mode write with a count byte pending
    reg_write(brlc_pkg::RegCapacity, 32'(CapMax));
    send_byte(8'd7, 1'b0);
    reg_write(brlc_pkg::RegMode, 32'(brlc_pkg::ModeExpand));
    send_byte(8'd1, 1'b0);
    send_byte(8'h33, 1'b1);
  endtask

  // longest run in both directions: run split at the cap, and a full-size count
  task automatic test_long_runs();
    byte_q_t msg;
    reg_write(brlc_pkg::RegMode, 32'(brlc_pkg::ModeCompress));
    repeat (300) msg.push_back(8'h77);
    send_message(msg);
    reg_write(brlc_pkg::RegMode, 32'(brlc_pkg::ModeExpand));
    send_byte(8'd255, 1'b0);
    send_byte(8'hC3, 1'b1);
  endtask

  task automatic test_random_phases();
    int unsigned sent;
    int unsigned cap;
    byte_q_t     msg;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0, 1:    cap = 32'(CapMax);
        2, 3:    cap = 0;
        4, 5:    cap = $urandom_range(1, 40);
        default: cap = $urandom_range(41, 32'(CapMax));
      endcase
      reg_write(brlc_pkg::RegMode, 32'(ph % 2));
      reg_write(brlc_pkg::RegCapacity, cap);
      sent = 0;
      while (sent < PhaseBytes) begin
        msg = (ph % 2 == 0) ? make_raw_message() : make_pair_message();
        send_message(msg);
        sent += msg.size();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: ready follows a rotating pattern, re-drawn when pat_age runs out,
  // sometimes all ones for a stall-free stretch
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (pat_age == 0) begin
      pat_age = 48;
      if ($urandom_range(0, 3) == 0) stall_pat = '1;
      else stall_pat = 16'($urandom_range(0, 16'hFFFF)) | 16'h0001;
    end
    pat_age--;
    stall_pat = {stall_pat[14:0], stall_pat[15]};
    out_if.ready <= stall_pat[0];
  end

  // --------------------------------------------------------------------------
  // Result checker: each accepted word against the oldest predicted one
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    word_t got;
    word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.bytes  = out_if.out_bytes;
      got.count  = out_if.byte_count;
      got.eom    = out_if.end_of_message;
      got.status = brlc_pkg::status_e'(out_if.status);
      got.total  = out_if.total_length;
      if (words_due.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing due: bytes %h count %0d eom %b st %0d tot %0d",
                 $time, got.bytes, got.count, got.eom, got.status, got.total);
      end else begin
        want = words_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch exp bytes %h cnt %0d eom %b st %0d tot %0d",
                   $time, want.bytes, want.count, want.eom, want.status, want.total);
          $display("%0t:          got bytes %h cnt %0d eom %b st %0d tot %0d",
                   $time, got.bytes, got.count, got.eom, got.status, got.total);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: any request on either channel or the bus counts as progress
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.in_last   = 1'b0;
    out_if.ready    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    rst_ni          = 1'b0;
    cur_mode        = brlc_pkg::ModeCompress;
    cur_cap         = 32'(CapMax);
    dropping        = 1'b0;
    clear_message();

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_registers();
    test_compress_cases();
    test_expand_cases();
    test_long_runs();
    test_random_phases();
    settle();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
